/* src/tbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tbc_pkg;

    localparam int THR_W    = 8;
    localparam int CFG_W    = 13;
    localparam int SUM_W    = 36;
    localparam int CNT_W    = 25;
    localparam int COORD_W  = 12;
    // Wide enough for column/row arithmetic at the largest allowed frame size.
    localparam int WIDE_W   = 17;
    localparam int STEP_W   = 4;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'h80;
    localparam logic [CFG_W-1:0] WIDTH_RESET     = 13'd640;

    localparam logic REG_THRESHOLD   = 1'b0;
    localparam logic REG_FRAME_WIDTH = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0] count;
    } t_frame_sums;

endpackage
`default_nettype wire

/* src/tbc_pix_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface tbc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       last_pixel;

    modport source (output valid, output pixel_value, output last_pixel, input ready);
    modport sink (input valid, input pixel_value, input last_pixel, output ready);
endinterface
`default_nettype wire

/* src/tbc_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface tbc_res_if;
    logic        valid;
    logic        ready;
    logic [11:0] centroid_x;
    logic [11:0] centroid_y;
    logic        found;
    logic [24:0] pixel_count;

    modport source (output valid, output centroid_x, output centroid_y, output found,
                    output pixel_count, input ready);
    modport sink (input valid, input centroid_x, input centroid_y, input found,
                  input pixel_count, output ready);
endinterface
`default_nettype wire

/* src/tbc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module tbc_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [tbc_pkg::CFG_W-1:0] i_cfg_data,
    tbc_pix_if.sink                        i_pix,
    input  wire logic                      i_q_full,
    output logic                           o_q_push,
    output tbc_pkg::t_frame_sums           o_q_data
);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WW    = tbc_pkg::WIDE_W;
    localparam int SW    = tbc_pkg::SUM_W;
    localparam int CW    = tbc_pkg::CNT_W;

    logic [tbc_pkg::THR_W-1:0] r_thr;
    logic [tbc_pkg::CFG_W-1:0] r_width;
    logic [COL_W-1:0]          r_col, n_col;
    logic [ROW_W-1:0]          r_row, n_row;
    logic [SW-1:0]             r_sx, n_sx;
    logic [SW-1:0]             r_sy, n_sy;
    logic [CW-1:0]             r_cnt, n_cnt;

    logic          accept;
    logic          hit;
    logic [WW-1:0] eff_w;
    logic [SW:0]   add_x;
    logic [SW:0]   add_y;

    assign i_pix.ready = !i_q_full;
    assign accept      = i_pix.valid && !i_q_full;
    assign hit         = i_pix.pixel_value > r_thr;

    always_comb begin
        eff_w = WW'(r_width);
        if (r_width == '0) begin
            eff_w = WW'(1);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end
    end

    assign add_x = {1'b0, r_sx} + (SW + 1)'(r_col);
    assign add_y = {1'b0, r_sy} + (SW + 1)'(r_row);

    // Running sums including the current pixel; saturate instead of wrapping.
    always_comb begin
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_cnt = r_cnt;
        if (hit) begin
            n_sx  = add_x[SW] ? '1 : add_x[SW-1:0];
            n_sy  = add_y[SW] ? '1 : add_y[SW-1:0];
            n_cnt = (r_cnt == '1) ? r_cnt : r_cnt + CW'(1);
        end
    end

    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (WW'(r_col) + WW'(1) >= eff_w) begin
            n_col = '0;
            if (WW'(r_row) + WW'(1) < WW'(MAX_HEIGHT)) begin
                n_row = r_row + ROW_W'(1);
            end
        end
    end

    assign o_q_push       = accept && i_pix.last_pixel;
    assign o_q_data.sum_x = n_sx;
    assign o_q_data.sum_y = n_sy;
    assign o_q_data.count = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= tbc_pkg::THRESHOLD_RESET;
            r_width <= tbc_pkg::WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbc_pkg::REG_THRESHOLD:   r_thr   <= i_cfg_data[tbc_pkg::THR_W-1:0];
                tbc_pkg::REG_FRAME_WIDTH: r_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            if (i_pix.last_pixel) begin
                r_col <= '0;
                r_row <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_cnt <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
                r_sx  <= n_sx;
                r_sy  <= n_sy;
                r_cnt <= n_cnt;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> (r_col == '0) && (r_row == '0) && (r_cnt == '0) && (r_sx == '0))
        else $error("frame state not cleared after last pixel");

    a_count_implies_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_sx == '0) && (r_sy == '0))
        else $error("nonzero sums with zero hit count");

endmodule
`default_nettype wire

/* src/tbc_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module tbc_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  tbc_pkg::t_frame_sums       i_data,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output tbc_pkg::t_frame_sums       o_data
);
    tbc_pkg::t_frame_sums r_mem [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop) && !(i_pop && !o_valid))
        else $error("frame queue overflow or underflow");

endmodule
`default_nettype wire

/* src/tbc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module tbc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    output logic                 o_q_pop,
    input  tbc_pkg::t_frame_sums i_q_data,
    tbc_res_if.source            o_res
);
    localparam int SW = tbc_pkg::SUM_W;
    localparam int CW = tbc_pkg::CNT_W;
    localparam int QW = tbc_pkg::COORD_W;
    localparam int TW = tbc_pkg::STEP_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state;
    logic [TW-1:0] r_step;
    logic [SW-1:0] r_rem_x;
    logic [SW-1:0] r_rem_y;
    logic [CW-1:0] r_den;
    logic [SW-1:0] r_dsh;
    logic [QW-1:0] r_qx;
    logic [QW-1:0] r_qy;
    logic          r_clx;
    logic          r_cly;

    logic          r_out_valid;
    logic [QW-1:0] r_out_x;
    logic [QW-1:0] r_out_y;
    logic          r_out_found;
    logic [CW-1:0] r_out_cnt;

    logic          load_out;
    logic          ge_x;
    logic          ge_y;

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || o_res.ready);
    assign ge_x     = r_rem_x >= r_dsh;
    assign ge_y     = r_rem_y >= r_dsh;

    // Quotients above the coordinate range are caught up front, so a fixed
    // number of restoring steps yields the rest.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rem_x <= i_q_data.sum_x;
                r_rem_y <= i_q_data.sum_y;
                r_den   <= i_q_data.count;
            end
            S_CHK: begin
                r_clx  <= {1'b0, r_rem_x} >= {r_den, {QW{1'b0}}};
                r_cly  <= {1'b0, r_rem_y} >= {r_den, {QW{1'b0}}};
                r_dsh  <= {r_den, {(QW - 1){1'b0}}};
                r_qx   <= '0;
                r_qy   <= '0;
                r_step <= TW'(QW - 1);
            end
            S_DIV: begin
                if (ge_x) begin
                    r_rem_x <= r_rem_x - r_dsh;
                end
                if (ge_y) begin
                    r_rem_y <= r_rem_y - r_dsh;
                end
                r_qx   <= {r_qx[QW-2:0], ge_x};
                r_qy   <= {r_qy[QW-2:0], ge_y};
                r_dsh  <= r_dsh >> 1;
                r_step <= r_step - TW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_state <= (r_den == '0) ? S_DONE : S_DIV;
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_found <= r_den != '0;
            r_out_cnt   <= r_den;
            if (r_den == '0) begin
                r_out_x <= '0;
                r_out_y <= '0;
            end else begin
                r_out_x <= r_clx ? '1 : r_qx;
                r_out_y <= r_cly ? '1 : r_qy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.centroid_x  = r_out_x;
    assign o_res.centroid_y  = r_out_y;
    assign o_res.found       = r_out_found;
    assign o_res.pixel_count = r_out_cnt;

    a_empty_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> (r_out_x == '0) && (r_out_y == '0)
            && (r_out_cnt == '0))
        else $error("empty frame reported with nonzero fields");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_CHK))
        else $error("divider did not start after taking a frame");

endmodule
`default_nettype wire

/* src/threshold_blob_centroid_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Threshold blob centroid unit.
// i_pix carries one grayscale pixel per request in raster order; last_pixel
// marks the final pixel of a frame. Column and row are tracked internally from
// the frame_width register (index 1); pixels strictly above the threshold
// register (index 0) are summed and counted. The user must write registers through
// i_cfg_we / i_cfg_idx / i_cfg_data only while the block is idle; the block does not enforce this.
// o_res delivers one request per frame: floor of the mean column and row
// (clamped to 4095), a found flag and the hit count.
// Pixels are taken at one per cycle while the queue is not full. The last pixel
// hands the frame sums to a two-entry queue; a restoring divider then produces
// one quotient bit per cycle over 12 bits, and a frame with no hits skips the
// divide. Pixel input stalls only when two finished frames are queued behind
// the divider.
// When the receiver stalls, the result is held in the output register and the
// divider waits; pixels are still accepted meanwhile until the queue is full.
// Reset (synchronous, active low) restores threshold 128 and width 640 and
// clears position, sums and any pending result.
module threshold_blob_centroid_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [tbc_pkg::CFG_W-1:0] i_cfg_data,
    tbc_pix_if.sink                        i_pix,
    tbc_res_if.source                      o_res
);
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_valid;
    tbc_pkg::t_frame_sums q_wdata;
    tbc_pkg::t_frame_sums q_rdata;

    tbc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    tbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    tbc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_data  (q_rdata),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire
